### src/thw_pkg.sv
// ----------------------------------------------------------------------------
// thw_pkg
// Shared types and constants of the tiered heartbeat watchdog.
// ----------------------------------------------------------------------------
package thw_pkg;

    // Input item opcodes
    localparam logic OP_HEARTBEAT = 1'b0;
    localparam logic OP_TICK      = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_MAX_FAILURES   = 1'b0;
    localparam logic REG_WARN_THRESHOLD = 1'b1;

    localparam int unsigned PADDR_WIDTH = 3;
    localparam int unsigned PDATA_WIDTH = 32;

    localparam logic [7:0] MAX_FAILURES_RST   = 8'd10;
    localparam logic [6:0] WARN_THRESHOLD_RST = 7'd5;

    // Miss timing. The count is kept as (elapsed + STALE_OFFSET) split into
    // whole periods and a remainder, so misses = periods, except at exactly
    // STALE_START_MS where it is still zero.
    localparam int unsigned STALE_START_MS = 5000;
    localparam int unsigned MISS_PERIOD_MS = 5500;
    localparam int unsigned STALE_OFFSET   = MISS_PERIOD_MS - STALE_START_MS;
    localparam int unsigned REM_WIDTH      = 13;
    localparam int unsigned SUM_WIDTH      = 17;
    // Most periods one 16-bit tick plus a remainder can carry
    localparam int unsigned MAX_CARRY      = 12;
    localparam int unsigned CARRY_WIDTH    = 4;

    typedef struct packed {
        logic        op;
        logic [15:0] tick_ms;
    } in_word_t;

    typedef struct packed {
        logic [7:0] miss_count;
        logic       warn_event;
        logic       fault_event;
        logic       latch_event;
    } out_word_t;

    typedef struct packed {
        logic [7:0] max_failures;
        logic [6:0] warn_threshold;
    } cfg_t;

    typedef struct packed {
        logic emits;    // current item gives a result word
        logic latched;  // fault latched, block inert
    } eng_status_t;

endpackage

### src/thw_apb_regs.sv
// ----------------------------------------------------------------------------
// thw_apb_regs
// APB register file: max_failures and warn_threshold.
// ----------------------------------------------------------------------------
module thw_apb_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [thw_pkg::PADDR_WIDTH-1:0]      paddr,
    input  logic [thw_pkg::PDATA_WIDTH-1:0]      pwdata,
    output logic [thw_pkg::PDATA_WIDTH-1:0]      prdata,
    output logic                                 pready,
    output thw_pkg::cfg_t                        cfg
);

    thw_pkg::cfg_t cfg_reg;
    thw_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                thw_pkg::REG_MAX_FAILURES:   cfg_next.max_failures   = pwdata[7:0];
                thw_pkg::REG_WARN_THRESHOLD: cfg_next.warn_threshold = pwdata[6:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            thw_pkg::REG_MAX_FAILURES:
                prdata = {24'd0, cfg_reg.max_failures};
            thw_pkg::REG_WARN_THRESHOLD:
                prdata = {25'd0, cfg_reg.warn_threshold};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_failures   <= thw_pkg::MAX_FAILURES_RST;
            cfg_reg.warn_threshold <= thw_pkg::WARN_THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/thw_miss_engine.sv
// ----------------------------------------------------------------------------
// thw_miss_engine
// Watchdog state and combinational miss/tier evaluation for one word.
// ----------------------------------------------------------------------------
module thw_miss_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,   // word leaves the input stage
    input  thw_pkg::in_word_t     item,
    input  thw_pkg::cfg_t         cfg,
    output thw_pkg::out_word_t    res,
    output thw_pkg::eng_status_t  status
);

    typedef struct packed {
        logic [thw_pkg::CARRY_WIDTH-1:0] carry;
        logic [thw_pkg::REM_WIDTH-1:0]   rem;
    } split_t;

    // Whole periods in s (s < 13 periods) and what is left over
    function automatic split_t period_split(input logic [thw_pkg::SUM_WIDTH-1:0] s);
        split_t                        sp;
        logic [thw_pkg::SUM_WIDTH-1:0] base;
        sp.carry = '0;
        base     = '0;
        for (int k = 1; k <= int'(thw_pkg::MAX_CARRY); k++)
        begin
            if (s >= thw_pkg::SUM_WIDTH'(k * thw_pkg::MISS_PERIOD_MS))
            begin
                sp.carry = thw_pkg::CARRY_WIDTH'(k);
                base     = thw_pkg::SUM_WIDTH'(k * thw_pkg::MISS_PERIOD_MS);
            end
        end
        sp.rem = thw_pkg::REM_WIDTH'(s - base);
        return sp;
    endfunction

    // periods_reg saturates at 255: beyond that only min(.., max_failures)
    // matters, which is then max_failures anyway.
    logic [7:0]                     periods_reg, periods_next;
    logic [thw_pkg::REM_WIDTH-1:0]  rem_reg, rem_next;
    logic [7:0]                     prev_reg, prev_next;
    logic                           latched_reg, latched_next;

    logic [thw_pkg::SUM_WIDTH-1:0]  sum;
    split_t                         sp;
    logic [8:0]                     per_sum;
    logic [7:0]                     per_new;
    logic                           not_stale;
    logic [7:0]                     miss;
    logic [7:0]                     prev_eff;
    logic [7:0]                     warn_thr;
    logic                           latch;

    assign sum      = thw_pkg::SUM_WIDTH'(rem_reg) + thw_pkg::SUM_WIDTH'(item.tick_ms);
    assign sp       = period_split(sum);
    assign per_sum  = 9'(periods_reg) + 9'(sp.carry);
    assign per_new  = (per_sum > 9'd255) ? 8'd255 : per_sum[7:0];
    // exactly at the stale start the offset count is one period, no remainder
    assign not_stale = (per_new != 8'd0) && !((per_new == 8'd1) && (sp.rem == '0));
    assign miss     = !not_stale ? 8'd0 :
                      (per_new > cfg.max_failures) ? cfg.max_failures : per_new;
    assign prev_eff = (miss == 8'd0) ? 8'd0 : prev_reg;
    assign warn_thr = {1'b0, cfg.warn_threshold};
    assign latch    = (miss >= cfg.max_failures);

    always_comb
    begin
        res.miss_count  = miss;
        res.warn_event  = (miss > prev_eff) && (miss != 8'd0) && (miss <= warn_thr);
        res.fault_event = (miss > warn_thr) && (miss < cfg.max_failures) &&
                          (prev_eff <= warn_thr);
        res.latch_event = latch;
    end

    assign status.emits   = !latched_reg && (item.op == thw_pkg::OP_TICK);
    assign status.latched = latched_reg;

    always_comb
    begin
        periods_next = periods_reg;
        rem_next     = rem_reg;
        prev_next    = prev_reg;
        latched_next = latched_reg;
        if (step && !latched_reg)
        begin
            case (item.op)
                thw_pkg::OP_HEARTBEAT:
                begin
                    periods_next = 8'd0;
                    rem_next     = thw_pkg::REM_WIDTH'(thw_pkg::STALE_OFFSET);
                end
                thw_pkg::OP_TICK:
                begin
                    periods_next = per_new;
                    rem_next     = sp.rem;
                    prev_next    = miss;
                    latched_next = latch;
                end
                default:
                begin
                    periods_next = periods_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periods_reg <= 8'd0;
            rem_reg     <= thw_pkg::REM_WIDTH'(thw_pkg::STALE_OFFSET);
            prev_reg    <= 8'd0;
            latched_reg <= 1'b0;
        end
        else
        begin
            periods_reg <= periods_next;
            rem_reg     <= rem_next;
            prev_reg    <= prev_next;
            latched_reg <= latched_next;
        end
    end

endmodule

### src/tiered_heartbeat_watchdog_unit.sv
// ----------------------------------------------------------------------------
// tiered_heartbeat_watchdog_unit
// Heartbeat timeout watchdog with warn, active-fault and latch tiers.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_word): one word per heartbeat
// (op = 0) or poll tick (op = 1, tick_ms = ms since last tick).
// Output channel (out_valid / out_stall / out_word): one result word per
// tick while the fault is not latched; heartbeats and anything after the
// latch give no result.
// APB port: max_failures at 0x0, warn_threshold at 0x4; write only when idle.
// Path: an accepted word enters the input register, and a tick's result is
// then written to the result register, which drives out_word. Throughput:
// one word per cycle while out_stall is not holding a full result register
// with a tick's result waiting behind it.
// Stall: with the result register held by out_stall, one more word can sit
// in the input register; in_stall rises only when both are full. Words that
// give no result drain even while the output is stalled.
// Reset: elapsed time, previous miss count and the latch clear, registers
// return to 10 / 5. No clearing pass; ready the cycle after reset.
// Elapsed time is held as periods + remainder; periods saturate at 255, never
// below max_failures, so the miss count is exact.
// ----------------------------------------------------------------------------
module tiered_heartbeat_watchdog_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // input words
    input  logic                             in_valid,
    output logic                             in_stall,
    input  thw_pkg::in_word_t                in_word,
    // result words
    output logic                             out_valid,
    input  logic                             out_stall,
    output thw_pkg::out_word_t               out_word,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [thw_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [thw_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [thw_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                             pready
);

    thw_pkg::cfg_t         cfg;
    thw_pkg::out_word_t    res;
    thw_pkg::eng_status_t  status;

    // input stage
    logic                  stage_valid_reg, stage_valid_next;
    thw_pkg::in_word_t     stage_word_reg;
    // result stage
    logic                  out_valid_reg, out_valid_next;
    thw_pkg::out_word_t    out_word_reg;

    logic                  in_fire;
    logic                  step;
    logic                  res_load;

    thw_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    thw_miss_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (stage_word_reg),
        .cfg    (cfg),
        .res    (res),
        .status (status)
    );

    // Word leaves the input stage unless it has a result and the
    // result register is full and held.
    assign step     = stage_valid_reg &&
                      (!status.emits || !out_valid_reg || !out_stall);
    assign res_load = step && status.emits;
    assign in_stall = stage_valid_reg && !step;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (step)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_word_reg <= in_word;
        end
        if (res_load)
        begin
            out_word_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // once latched, only reset clears the fault
    a_latch_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        status.latched |=> status.latched)
        else $error("fault latch cleared without reset");

    // no result is produced from a latched block
    a_no_res_latched: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !status.latched)
        else $error("result produced while latched");

    // the fault tier excludes the warn and latch tiers
    a_tiers_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_word.warn_event && out_word.fault_event) &&
                      !(out_word.fault_event && out_word.latch_event))
        else $error("more than one tier event in a result word");

    // a result loaded behind a held one would overwrite it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !res_load)
        else $error("result register overwritten while stalled");

endmodule
